// ===== sv/ddo_pkg.sv =====
// Shared constants, types and tables of the differential drive odometry block.
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int CFG_W        = 18;
	localparam int CFG_IDX_W    = 2;

	localparam int MUL_W     = 36;
	localparam int MUL_DIG   = 9;
	localparam int MUL_STEPS = MUL_W / MUL_DIG;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_BITS  = 56;
	localparam int CNT_W     = $clog2(DIV_BITS);
	localparam int COR_W     = 34;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_RADIUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROS         = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] HALF_RADIUS_RST = CFG_W'(1081);
	localparam logic [CFG_W-1:0] ROS_RST         = CFG_W'(12722);

	localparam logic signed [MUL_W-1:0] BAM_PER_RAD  = MUL_W'(683565276);
	localparam logic signed [MUL_W-1:0] USEC_PER_SEC = MUL_W'(1000000);
	localparam logic signed [COR_W-1:0] CORDIC_START = COR_W'(652032874);

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CORDIC_INIT, OP_CORDIC, OP_MUL, OP_STORE,
		OP_DIV, OP_DSTORE, OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		SEL_DS, SEL_DTH, SEL_BAM, SEL_HEAD, SEL_X, SEL_Y, SEL_HALF, SEL_VL, SEL_VA
	} sel_t;

	typedef struct packed {
		op_t              op;
		sel_t             sel;
		logic [CNT_W-1:0] idx;
		logic             idle;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		case (i)
			5'd0:  return 32'd536870912;
			5'd1:  return 32'd316933406;
			5'd2:  return 32'd167458907;
			5'd3:  return 32'd85004756;
			5'd4:  return 32'd42667331;
			5'd5:  return 32'd21354465;
			5'd6:  return 32'd10679838;
			5'd7:  return 32'd5340245;
			5'd8:  return 32'd2670163;
			5'd9:  return 32'd1335087;
			5'd10: return 32'd667544;
			5'd11: return 32'd333772;
			5'd12: return 32'd166886;
			5'd13: return 32'd83443;
			5'd14: return 32'd41722;
			5'd15: return 32'd20861;
			5'd16: return 32'd10430;
			5'd17: return 32'd5215;
			5'd18: return 32'd2608;
			5'd19: return 32'd1304;
			5'd20: return 32'd652;
			5'd21: return 32'd326;
			5'd22: return 32'd163;
			5'd23: return 32'd81;
			5'd24: return 32'd41;
			5'd25: return 32'd20;
			5'd26: return 32'd10;
			5'd27: return 32'd5;
			5'd28: return 32'd3;
			5'd29: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

endpackage

// ===== sv/ddo_if.sv =====
// Handshake channel interfaces: wheel sample, pose result and configuration write.
interface ddo_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_position;
	logic [31:0] right_position;
	logic [31:0] stamp_us;
	modport source (output valid, left_position, right_position, stamp_us, input ready);
	modport sink (input valid, left_position, right_position, stamp_us, output ready);
endinterface

interface ddo_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pose_x;
	logic [31:0] pose_y;
	logic [31:0] heading_angle;
	logic [31:0] linear_speed;
	logic [31:0] angular_speed;
	logic [15:0] quat_z;
	logic [15:0] quat_w;
	logic        zero_interval;
	modport source (output valid, pose_x, pose_y, heading_angle, linear_speed,
		angular_speed, quat_z, quat_w, zero_interval, input ready);
	modport sink (input valid, pose_x, pose_y, heading_angle, linear_speed,
		angular_speed, quat_z, quat_w, zero_interval, output ready);
endinterface

interface ddo_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ddo_pkg::CFG_IDX_W-1:0] index;
	logic [ddo_pkg::CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ddo_ctrl.sv =====
// Sequencer for the odometry datapath: multiply, CORDIC and divide passes.
module ddo_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ddo_pkg::stat_t stat,
	output ddo_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_STEP, S_STORE, S_DIV, S_DSTORE, S_OUT
	} state_t;

	state_t                    state_q;
	ddo_pkg::sel_t             phase_q;
	logic [ddo_pkg::CNT_W-1:0] cnt_q;

	logic is_cordic;
	logic step_last;

	assign is_cordic = (phase_q == ddo_pkg::SEL_HEAD) || (phase_q == ddo_pkg::SEL_HALF);
	assign step_last = is_cordic ? (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::CORDIC_STEPS - 1))
	                             : (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::MUL_STEPS - 1));

	function automatic ddo_pkg::sel_t next_phase(input ddo_pkg::sel_t p);
		case (p)
			ddo_pkg::SEL_DS:   return ddo_pkg::SEL_DTH;
			ddo_pkg::SEL_DTH:  return ddo_pkg::SEL_BAM;
			ddo_pkg::SEL_BAM:  return ddo_pkg::SEL_HEAD;
			ddo_pkg::SEL_HEAD: return ddo_pkg::SEL_X;
			ddo_pkg::SEL_X:    return ddo_pkg::SEL_Y;
			ddo_pkg::SEL_Y:    return ddo_pkg::SEL_HALF;
			default:           return ddo_pkg::SEL_VL;
		endcase
	endfunction

	always_comb begin
		cmd.op   = ddo_pkg::OP_NONE;
		cmd.sel  = phase_q;
		cmd.idx  = cnt_q;
		cmd.idle = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:   if (stat.in_valid) cmd.op = ddo_pkg::OP_LOAD;
			S_INIT:   cmd.op = ddo_pkg::OP_CORDIC_INIT;
			S_STEP:   cmd.op = is_cordic ? ddo_pkg::OP_CORDIC : ddo_pkg::OP_MUL;
			S_STORE:  cmd.op = ddo_pkg::OP_STORE;
			S_DIV:    cmd.op = ddo_pkg::OP_DIV;
			S_DSTORE: cmd.op = ddo_pkg::OP_DSTORE;
			S_OUT:    if (stat.out_free) cmd.op = ddo_pkg::OP_OUT;
			default:  cmd.op = ddo_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= ddo_pkg::SEL_DS;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (stat.in_valid) begin
						state_q <= S_STEP;
						phase_q <= ddo_pkg::SEL_DS;
						cnt_q   <= '0;
					end
				end
				S_INIT: begin
					state_q <= S_STEP;
					cnt_q   <= '0;
				end
				S_STEP: begin
					if (step_last) state_q <= S_STORE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_STORE: begin
					cnt_q <= '0;
					if (phase_q == ddo_pkg::SEL_VL || phase_q == ddo_pkg::SEL_VA) begin
						state_q <= S_DIV;
					end else begin
						phase_q <= next_phase(phase_q);
						if (next_phase(phase_q) == ddo_pkg::SEL_HEAD ||
						    next_phase(phase_q) == ddo_pkg::SEL_HALF)
							state_q <= S_INIT;
						else
							state_q <= S_STEP;
					end
				end
				S_DIV: begin
					if (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::DIV_BITS - 1)) state_q <= S_DSTORE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DSTORE: begin
					cnt_q <= '0;
					if (phase_q == ddo_pkg::SEL_VL) begin
						phase_q <= ddo_pkg::SEL_VA;
						state_q <= S_STEP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/ddo_dpath.sv =====
// Odometry datapath: state, digit-serial multiplier, CORDIC, divider, result register.
module ddo_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  ddo_pkg::cmd_t  cmd,
	output ddo_pkg::stat_t stat,
	ddo_in_if.sink         sample,
	ddo_out_if.source      pose,
	ddo_cfg_if.sink        cfg
);

	localparam int PW = ddo_pkg::PROD_W;
	localparam int MW = ddo_pkg::MUL_W;
	localparam int DG = ddo_pkg::MUL_DIG;
	localparam int PPW = MW + DG + 1;
	localparam int CW = ddo_pkg::COR_W;
	localparam int DB = ddo_pkg::DIV_BITS;
	localparam int FB = ddo_pkg::FRAC_BITS;

	logic [ddo_pkg::CFG_W-1:0] hr_q, ros_q;
	logic [31:0] last_left_q, last_right_q, last_stamp_q;
	logic [31:0] acc_x_q, acc_y_q, acc_head_q;
	logic        out_valid_q;

	logic signed [32:0] sum_q, dif_q;
	logic [31:0]        dt_q;
	logic signed [34:0] ds_q, dth_q;
	logic signed [CW-1:0] cos_q, sin_q;
	logic [15:0] qz_q, qw_q;
	logic [31:0] lin_q, ang_q;
	logic signed [PW-1:0] acc_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic                 cneg_q;
	logic [31:0]   rem_q;
	logic [DB-1:0] num_q;
	logic          dneg_q;
	logic [31:0] o_x_q, o_y_q, o_h_q, o_lin_q, o_ang_q;
	logic [15:0] o_qz_q, o_qw_q;
	logic        o_zero_q;

	// Multiplier: one 9-bit digit of b per cycle, top digit signed.
	logic signed [MW-1:0] a_op, b_op, b_sh;
	logic signed [DG:0]   dig;
	logic signed [PPW-1:0] pp;
	logic signed [PW-1:0]  pp_sh, acc_nx;
	logic [1:0]            k;

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.sel)
			ddo_pkg::SEL_DS:  begin a_op = MW'(sum_q); b_op = MW'({1'b0, hr_q}); end
			ddo_pkg::SEL_DTH: begin a_op = MW'(dif_q); b_op = MW'({1'b0, ros_q}); end
			ddo_pkg::SEL_BAM: begin a_op = MW'(dth_q); b_op = ddo_pkg::BAM_PER_RAD; end
			ddo_pkg::SEL_X:   begin a_op = MW'(ds_q);  b_op = MW'(cos_q); end
			ddo_pkg::SEL_Y:   begin a_op = MW'(ds_q);  b_op = MW'(sin_q); end
			ddo_pkg::SEL_VL:  begin a_op = MW'(ds_q);  b_op = ddo_pkg::USEC_PER_SEC; end
			ddo_pkg::SEL_VA:  begin a_op = MW'(dth_q); b_op = ddo_pkg::USEC_PER_SEC; end
			default:          begin a_op = '0; b_op = '0; end
		endcase
	end

	assign k      = cmd.idx[1:0];
	assign b_sh   = b_op >>> (DG * k);
	assign dig    = (k == 2'(ddo_pkg::MUL_STEPS - 1)) ? {b_sh[DG-1], b_sh[DG-1:0]}
	                                                  : {1'b0, b_sh[DG-1:0]};
	assign pp     = a_op * dig;
	assign pp_sh  = {{(PW-PPW){pp[PPW-1]}}, pp} <<< (DG * k);
	assign acc_nx = ((k == 2'd0) ? '0 : acc_q) + pp_sh;

	// Rounded views of the product.
	logic signed [PW-1:0] rnd16, rndf, rnd30;
	assign rnd16 = acc_q + (PW'(1) <<< 15);
	assign rndf  = acc_q + (PW'(1) <<< (FB - 1));
	assign rnd30 = acc_q + (PW'(1) <<< 29);

	// CORDIC step and fold.
	logic [31:0]          cang;
	logic signed [CW-1:0] xs, ys, at, fx, fy;
	assign cang = (cmd.sel == ddo_pkg::SEL_HALF) ? {1'b0, acc_head_q[31:1]} : acc_head_q;
	assign xs   = cx_q >>> cmd.idx[4:0];
	assign ys   = cy_q >>> cmd.idx[4:0];
	assign at   = $signed({2'b00, ddo_pkg::atan_bam(cmd.idx[4:0])});
	assign fx   = cneg_q ? -cx_q : cx_q;
	assign fy   = cneg_q ? -cy_q : cy_q;

	// Divider step, restoring, one quotient bit per cycle.
	logic [32:0] trial;
	logic        qbit;
	logic signed [DB-1:0] num_val;
	assign trial   = {rem_q, num_q[DB-1]};
	assign qbit    = trial >= {1'b0, dt_q};
	assign num_val = acc_q[DB-1:0];

	function automatic logic [15:0] quat_of(input logic signed [CW-1:0] v);
		logic signed [CW:0]   t;
		logic signed [CW-16:0] r;
		t = {v[CW-1], v} + (CW+1)'(32768);
		r = t[CW:16];
		if (r > (CW-15)'(16384)) return 16'd16384;
		if (r < -(CW-15)'(16384)) return 16'hC000;
		return r[15:0];
	endfunction

	function automatic logic [31:0] sat_quo(input logic [DB-1:0] q, input logic neg);
		if (neg) begin
			if (q > DB'(64'h8000_0000)) return 32'h8000_0000;
			return 32'(DB'(0) - q);
		end
		if (q > DB'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
		return q[31:0];
	endfunction

	logic [31:0] dl, dr;
	assign dl = sample.left_position - last_left_q;
	assign dr = sample.right_position - last_right_q;

	// Architectural state and control, under reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_q         <= ddo_pkg::HALF_RADIUS_RST;
			ros_q        <= ddo_pkg::ROS_RST;
			last_left_q  <= '0;
			last_right_q <= '0;
			last_stamp_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_head_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					ddo_pkg::REG_HALF_RADIUS: hr_q  <= cfg.data;
					ddo_pkg::REG_ROS:         ros_q <= cfg.data;
					default: ;
				endcase
			end
			if (cmd.op == ddo_pkg::OP_LOAD) begin
				last_left_q  <= sample.left_position;
				last_right_q <= sample.right_position;
				last_stamp_q <= sample.stamp_us;
			end
			if (cmd.op == ddo_pkg::OP_STORE) begin
				case (cmd.sel)
					ddo_pkg::SEL_BAM: acc_head_q <= acc_head_q + rndf[FB+31:FB];
					ddo_pkg::SEL_X:   acc_x_q    <= acc_x_q + rnd30[61:30];
					ddo_pkg::SEL_Y:   acc_y_q    <= acc_y_q + rnd30[61:30];
					default: ;
				endcase
			end
			if (cmd.op == ddo_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (pose.ready) out_valid_q <= 1'b0;
		end
	end

	// Working registers, no reset.
	always_ff @(posedge clk) begin
		case (cmd.op)
			ddo_pkg::OP_LOAD: begin
				sum_q <= $signed({dl[31], dl}) + $signed({dr[31], dr});
				dif_q <= $signed({dr[31], dr}) - $signed({dl[31], dl});
				dt_q  <= sample.stamp_us - last_stamp_q;
			end
			ddo_pkg::OP_MUL: acc_q <= acc_nx;
			ddo_pkg::OP_CORDIC_INIT: begin
				cneg_q <= cang[31] ^ cang[30];
				cz_q   <= CW'($signed({cang[31] ^ (cang[31] ^ cang[30]), cang[30:0]}));
				cx_q   <= ddo_pkg::CORDIC_START;
				cy_q   <= '0;
			end
			ddo_pkg::OP_CORDIC: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			ddo_pkg::OP_STORE: begin
				case (cmd.sel)
					ddo_pkg::SEL_DS:   ds_q  <= rnd16[50:16];
					ddo_pkg::SEL_DTH:  dth_q <= rnd16[50:16];
					ddo_pkg::SEL_HEAD: begin cos_q <= fx; sin_q <= fy; end
					ddo_pkg::SEL_HALF: begin qw_q <= quat_of(fx); qz_q <= quat_of(fy); end
					ddo_pkg::SEL_VL, ddo_pkg::SEL_VA: begin
						dneg_q <= num_val[DB-1];
						num_q  <= num_val[DB-1] ? DB'(-num_val) : num_val;
						rem_q  <= '0;
					end
					default: ;
				endcase
			end
			ddo_pkg::OP_DIV: begin
				rem_q <= qbit ? 32'(trial - {1'b0, dt_q}) : trial[31:0];
				num_q <= {num_q[DB-2:0], qbit};
			end
			ddo_pkg::OP_DSTORE: begin
				if (cmd.sel == ddo_pkg::SEL_VL)
					lin_q <= (dt_q == '0) ? '0 : sat_quo(num_q, dneg_q);
				else
					ang_q <= (dt_q == '0) ? '0 : sat_quo(num_q, dneg_q);
			end
			ddo_pkg::OP_OUT: begin
				o_x_q    <= acc_x_q;
				o_y_q    <= acc_y_q;
				o_h_q    <= acc_head_q;
				o_lin_q  <= lin_q;
				o_ang_q  <= ang_q;
				o_qz_q   <= qz_q;
				o_qw_q   <= qw_q;
				o_zero_q <= (dt_q == '0);
			end
			default: ;
		endcase
	end

	assign sample.ready       = cmd.idle;
	assign cfg.ready          = 1'b1;
	assign stat.in_valid      = sample.valid;
	assign stat.out_free      = !out_valid_q || pose.ready;
	assign pose.valid         = out_valid_q;
	assign pose.pose_x        = o_x_q;
	assign pose.pose_y        = o_y_q;
	assign pose.heading_angle = o_h_q;
	assign pose.linear_speed  = o_lin_q;
	assign pose.angular_speed = o_ang_q;
	assign pose.quat_z        = o_qz_q;
	assign pose.quat_w        = o_qw_q;
	assign pose.zero_interval = o_zero_q;

endmodule

// ===== sv/diff_drive_odometry.sv =====
// Takes one item at a time: a new item is accepted only while the sequencer is idle.
// Work per item: two 56-step restoring divisions, two 16-step CORDIC passes and
// seven 4-digit multiplies, all in one shared sequenced datapath.
// A finished result waits in the output register while the next item is accepted.
// Reset (arst_n low, asynchronous) clears pose, heading, stored angles and stamp
// and restores half_radius = 1081 and radius_over_separation = 12722.
module diff_drive_odometry (
	input logic       clk,
	input logic       arst_n,
	ddo_in_if.sink    sample,
	ddo_out_if.source pose,
	ddo_cfg_if.sink   cfg
);

	// Command and status between sequencer and datapath.
	ddo_pkg::cmd_t  cmd;
	ddo_pkg::stat_t stat;

	// Sequencer: steps each item through deltas, heading, CORDIC, pose and speeds.
	ddo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Datapath: holds the odometry state and the shared arithmetic units.
	ddo_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.sample (sample),
		.pose   (pose),
		.cfg    (cfg)
	);

endmodule

// ===== sv/ddo_checker.sv =====
// Port-level checks of the odometry block, bound to the top level.
module ddo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pose_x,
	input logic [31:0] linear_speed,
	input logic [31:0] angular_speed,
	input logic signed [15:0] quat_z,
	input logic        zero_interval
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pose_x))
		else $error("stalled result dropped or changed");

	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_interval |-> linear_speed == 32'd0 && angular_speed == 32'd0)
		else $error("speeds not zero on zero interval");

	a_quat_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_z >= 16'sd0 && quat_z <= 16'sd16384)
		else $error("quat_z outside half-turn range");

endmodule

bind diff_drive_odometry ddo_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (pose.valid),
	.out_ready     (pose.ready),
	.pose_x        (pose.pose_x),
	.linear_speed  (pose.linear_speed),
	.angular_speed (pose.angular_speed),
	.quat_z        (pose.quat_z),
	.zero_interval (pose.zero_interval)
);
